// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
package itp_pkg;
    localparam int SLOTS_DEFAULT = 1024;
    localparam int OP_W = 6;
    localparam int SLOT_W = 10;
    localparam int FLT_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int EPOCH_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_CODE    = 8'd0,
        REG_MAX_CODE    = 8'd1,
        REG_PASS_A_CODE = 8'd2,
        REG_PASS_B_CODE = 8'd3
    } cfg_reg_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } itp_state_t;

    typedef struct packed {
        logic          first_of_pass;
        logic [5:0]    opcode;
        logic [9:0]    clause_slot;
        logic [9:0]    slot_a;
        logic [9:0]    slot_b;
        logic [31:0]   a_lower;
        logic [31:0]   a_upper;
        logic [31:0]   b_lower;
        logic [31:0]   b_upper;
    } clause_t;
endpackage

// ===== rtl/itp_fge.sv =====
`timescale 1ns / 1ps
module itp_fge
    import itp_pkg::*;
(
    input  logic [FLT_W-1:0] x,
    input  logic [FLT_W-1:0] y,
    output logic             ge
);
    logic [FLT_W-1:0] kx;
    logic [FLT_W-1:0] ky;
    logic             x_nan;
    logic             y_nan;
    logic             both_zero;

    always_comb
    begin
        x_nan = x[FLT_W-2:0] > 31'h7f800000;
        y_nan = y[FLT_W-2:0] > 31'h7f800000;
        both_zero = (x[FLT_W-2:0] == '0) && (y[FLT_W-2:0] == '0);
        kx = x[FLT_W-1] ? ~x : {1'b1, x[FLT_W-2:0]};
        ky = y[FLT_W-1] ? ~y : {1'b1, y[FLT_W-2:0]};
        if (x_nan || y_nan)
        begin
            ge = 1'b0;
        end
        else if (both_zero)
        begin
            ge = 1'b1;
        end
        else
        begin
            ge = kx >= ky;
        end
    end
endmodule

// ===== rtl/interval_tape_pruner_unit.sv =====
`timescale 1ns / 1ps
// Prunes an expression tape at one clause per cycle. A clause is registered on
// acceptance while the epoch tag of its result slot is read from the needed map;
// in the next cycle its mark is checked, with the marks of the clause just before
// it forwarded, the min/max bound compares are made, and the surviving clause
// lands in the result register when the clause advances. The needed map is a
// memory of epoch tags: a slot is marked when its tag equals the current pass
// epoch, and slot 0 is always marked, so starting a pass costs nothing. After
// reset the block clears every slot of the map and holds in_stall high until it
// is done. The first clause of every 255th pass afterwards waits while the map
// is cleared again before the epoch wraps. Otherwise only a stalled result
// holds the input back.
module interval_tape_pruner_unit
    import itp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OP_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 first_of_pass,
    input  logic [OP_W-1:0]      opcode,
    input  logic [SLOT_W-1:0]    clause_slot,
    input  logic [SLOT_W-1:0]    slot_a,
    input  logic [SLOT_W-1:0]    slot_b,
    input  logic [FLT_W-1:0]     a_lower,
    input  logic [FLT_W-1:0]     a_upper,
    input  logic [FLT_W-1:0]     b_lower,
    input  logic [FLT_W-1:0]     b_upper,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OP_W-1:0]      out_opcode,
    output logic [SLOT_W-1:0]    out_slot,
    output logic [SLOT_W-1:0]    out_a,
    output logic [SLOT_W-1:0]    out_b
);
    localparam int IDX_W = $clog2(SLOTS);

    logic [OP_W-1:0] min_code_reg;
    logic [OP_W-1:0] max_code_reg;
    logic [OP_W-1:0] pass_a_code_reg;
    logic [OP_W-1:0] pass_b_code_reg;

    clause_t             clause_reg;
    logic                s1_valid_reg;
    logic [EPOCH_W-1:0]  tag_mem [SLOTS];
    logic [EPOCH_W-1:0]  tag_rd_reg;
    logic                fwd_hit_reg;
    logic [EPOCH_W-1:0]  epoch_reg;
    logic [IDX_W-1:0]    clear_idx_reg;
    itp_state_t          state_reg;
    itp_state_t          state_next;
    logic                out_valid_reg;
    logic [OP_W-1:0]     out_opcode_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [SLOT_W-1:0]   out_a_reg;
    logic [SLOT_W-1:0]   out_b_reg;

    logic                advance;
    logic                accept;
    logic                clearing;
    logic                clear_last;
    logic                wrap_hold;
    logic                marked;
    logic                slot_ok;
    logic                a_ok;
    logic                b_ok;
    logic                ge_al_bu;
    logic                ge_bl_au;
    logic                a_wins;
    logic                b_wins;
    logic                mark_a;
    logic                mark_b;
    logic                fwd_hit;
    logic [EPOCH_W-1:0]  new_epoch;

    itp_fge u_ge_al_bu
    (
        .x  (clause_reg.a_lower),
        .y  (clause_reg.b_upper),
        .ge (ge_al_bu)
    );

    itp_fge u_ge_bl_au
    (
        .x  (clause_reg.b_lower),
        .y  (clause_reg.a_upper),
        .ge (ge_bl_au)
    );

    assign clear_last = clear_idx_reg == IDX_W'(SLOTS - 1);
    assign wrap_hold  = s1_valid_reg && clause_reg.first_of_pass && (epoch_reg == '1);
    assign advance    = s1_valid_reg && !clearing && !wrap_hold
                        && !(out_valid_reg && out_stall);
    assign in_stall   = clearing || (s1_valid_reg && !advance);
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        case (state_reg)
            ST_CLEAR: state_next = clear_last ? ST_RUN : ST_CLEAR;
            ST_RUN:   state_next = wrap_hold ? ST_CLEAR : ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b0;
        endcase
    end

    always_comb
    begin
        slot_ok = 32'(clause_reg.clause_slot) < 32'(SLOTS);
        a_ok = 32'(clause_reg.slot_a) < 32'(SLOTS);
        b_ok = 32'(clause_reg.slot_b) < 32'(SLOTS);
        marked = (clause_reg.clause_slot == '0)
                 || (slot_ok && !clause_reg.first_of_pass
                     && (fwd_hit_reg || (tag_rd_reg == epoch_reg)));
        a_wins = 1'b0;
        b_wins = 1'b0;
        if (clause_reg.opcode == max_code_reg)
        begin
            a_wins = ge_al_bu;
            b_wins = !ge_al_bu && ge_bl_au;
        end
        else if (clause_reg.opcode == min_code_reg)
        begin
            b_wins = ge_al_bu;
            a_wins = !ge_al_bu && ge_bl_au;
        end
        mark_a = marked && !b_wins;
        mark_b = marked && !a_wins;
        new_epoch = clause_reg.first_of_pass ? epoch_reg + EPOCH_W'(1) : epoch_reg;
        fwd_hit = advance && ((mark_a && clause_reg.slot_a == clause_slot)
                              || (mark_b && clause_reg.slot_b == clause_slot));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_code_reg    <= OP_W'(0);
            max_code_reg    <= OP_W'(1);
            pass_a_code_reg <= OP_W'(2);
            pass_b_code_reg <= OP_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_CODE:    min_code_reg    <= cfg_data;
                REG_MAX_CODE:    max_code_reg    <= cfg_data;
                REG_PASS_A_CODE: pass_a_code_reg <= cfg_data;
                REG_PASS_B_CODE: pass_b_code_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            epoch_reg     <= EPOCH_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clear_idx_reg <= clear_last ? '0 : clear_idx_reg + IDX_W'(1);
            end
            if (!clearing && wrap_hold)
            begin
                epoch_reg <= '0;
            end
            else if (advance)
            begin
                epoch_reg <= new_epoch;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= marked;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            tag_mem[clear_idx_reg] <= '0;
        end
        else if (advance)
        begin
            if (mark_a && a_ok)
            begin
                tag_mem[IDX_W'(clause_reg.slot_a)] <= new_epoch;
            end
            if (mark_b && b_ok && !(mark_a && a_ok && clause_reg.slot_a == clause_reg.slot_b))
            begin
                tag_mem[IDX_W'(clause_reg.slot_b)] <= new_epoch;
            end
        end
        if (accept)
        begin
            tag_rd_reg <= tag_mem[IDX_W'(clause_slot)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clause_reg <= '{first_of_pass, opcode, clause_slot, slot_a, slot_b,
                            a_lower, a_upper, b_lower, b_upper};
            fwd_hit_reg <= fwd_hit;
        end
        if (advance && marked)
        begin
            out_slot_reg <= clause_reg.clause_slot;
            if (a_wins)
            begin
                out_opcode_reg <= pass_a_code_reg;
                out_a_reg      <= clause_reg.slot_a;
                out_b_reg      <= '0;
            end
            else if (b_wins)
            begin
                out_opcode_reg <= pass_b_code_reg;
                out_a_reg      <= '0;
                out_b_reg      <= clause_reg.slot_b;
            end
            else
            begin
                out_opcode_reg <= clause_reg.opcode;
                out_a_reg      <= clause_reg.slot_a;
                out_b_reg      <= clause_reg.slot_b;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_opcode = out_opcode_reg;
    assign out_slot   = out_slot_reg;
    assign out_a      = out_a_reg;
    assign out_b      = out_b_reg;

    // A result appears only when a clause left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a clause");

    // No clause is processed while the map is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !advance)
        else $error("clause processed during map clear");

    // A pruned min or max never keeps both operands.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(a_wins && b_wins))
        else $error("both operands chosen");
endmodule
